/* design/dot_matrix_frame_buffer_top_defines.svh */
// Assertion macros for the dot-matrix frame buffer.
// Included by the top level; no other dependencies.
`ifndef DOT_MATRIX_FRAME_BUFFER_TOP_DEFINES_SVH
`define DOT_MATRIX_FRAME_BUFFER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DMFB_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dmfb assertion failed");
`define DMFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmfb sequencing assertion failed");
`else
`define DMFB_ASSERT(label, prop)
`define DMFB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/dmfb_pkg.sv */
// Shared types, constants and glyph tables of the dot-matrix frame buffer.
// No dependencies.
package dmfb_pkg;

    localparam int ROWS  = 10;
    localparam int COLS  = 7;
    localparam int ROW_W = 4;
    localparam int COL_W = 3;

    typedef logic [COLS-1:0]  t_row;
    typedef logic [ROW_W-1:0] t_row_idx;
    typedef logic [COL_W-1:0] t_col_idx;

    localparam t_row ROW_MASK = '1;
    localparam t_row LEFT_BIT = t_row'(1) << (COLS - 1);

    localparam t_row GLYPH_ONE [ROWS] = '{
        7'h0c, 7'h1c, 7'h1c, 7'h0c, 7'h0c, 7'h0c, 7'h0c, 7'h0c, 7'h0c, 7'h1e
    };
    localparam t_row GLYPH_A [ROWS] = '{
        7'h1c, 7'h36, 7'h63, 7'h63, 7'h63, 7'h7f, 7'h7f, 7'h63, 7'h63, 7'h63
    };

    typedef enum logic [2:0] {
        K_CLEAR    = 3'd0,
        K_LOAD_ONE = 3'd1,
        K_LOAD_A   = 3'd2,
        K_SET      = 3'd3,
        K_INVERT   = 3'd4,
        K_PRINT    = 3'd5,
        K_BLINK    = 3'd6,
        K_NONE     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_STREAM
    } t_state;

    typedef struct packed {
        logic latch;
        logic apply;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_row;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/dmfb_ctrl.sv */
// Command sequencer of the dot-matrix frame buffer: accept, apply, stream rows.
// Depends on dmfb_pkg.
module dmfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  dmfb_pkg::t_kind   i_req_kind,
    output logic              o_req_ready,
    input  dmfb_pkg::t_dp_stat i_stat,
    output dmfb_pkg::t_dp_cmd o_cmd
);
    import dmfb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid && (i_req_kind != K_NONE)) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_STREAM;
            end
            S_STREAM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_row) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/dmfb_datapath.sv */
// Frame store, blink phase, row counter and output register of the frame buffer.
// Depends on dmfb_pkg.
module dmfb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmfb_pkg::t_dp_cmd   i_cmd,
    output dmfb_pkg::t_dp_stat  o_stat,
    input  dmfb_pkg::t_kind     i_kind,
    input  dmfb_pkg::t_row_idx  i_row_sel,
    input  dmfb_pkg::t_col_idx  i_col_sel,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dmfb_pkg::t_row_idx  o_row_index,
    output dmfb_pkg::t_row      o_row_bits,
    output logic                o_last_row
);
    import dmfb_pkg::*;

    t_row     r_frame [ROWS];
    logic     r_blink_phase;
    logic     r_out_valid;
    t_row_idx r_cnt;
    t_kind    r_kind;
    t_row_idx r_row;
    t_col_idx r_col;
    t_row_idx r_tog_row;
    t_row     r_tog_bits;
    t_row_idx r_out_index;
    t_row     r_out_bits;
    logic     r_out_last;

    logic pix_valid;
    t_row pix_bit;
    t_row n_bits;
    logic last_cnt;

    assign pix_valid = (r_row < t_row_idx'(ROWS)) && ({1'b0, r_col} < (COL_W + 1)'(COLS));
    assign pix_bit   = (LEFT_BIT >> r_col) & ROW_MASK;
    assign last_cnt  = (r_cnt == t_row_idx'(ROWS - 1));
    assign n_bits    = r_frame[r_cnt] ^ ((r_cnt == r_tog_row) ? r_tog_bits : '0);

    assign o_stat.last_row = last_cnt;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '0;
            end
            r_blink_phase <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cmd.apply) begin
                r_cnt <= '0;
                unique case (r_kind)
                    K_CLEAR: begin
                        for (int r = 0; r < ROWS; r++) begin
                            r_frame[r] <= '0;
                        end
                    end
                    K_LOAD_ONE: begin
                        for (int r = 0; r < ROWS; r++) begin
                            r_frame[r] <= GLYPH_ONE[r] & ROW_MASK;
                        end
                    end
                    K_LOAD_A: begin
                        for (int r = 0; r < ROWS; r++) begin
                            r_frame[r] <= GLYPH_A[r] & ROW_MASK;
                        end
                    end
                    K_SET: begin
                        if (pix_valid) begin
                            r_frame[r_row] <= r_frame[r_row] | pix_bit;
                        end
                    end
                    K_INVERT: begin
                        for (int r = 0; r < ROWS; r++) begin
                            r_frame[r] <= r_frame[r] ^ ROW_MASK;
                        end
                    end
                    K_BLINK: begin
                        r_blink_phase <= !r_blink_phase;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt + t_row_idx'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_row  <= i_row_sel;
            r_col  <= i_col_sel;
        end
        if (i_cmd.apply) begin
            r_tog_row  <= r_row;
            r_tog_bits <= ((r_kind == K_BLINK) && r_blink_phase && pix_valid) ? pix_bit : '0;
        end
        if (i_cmd.emit) begin
            r_out_index <= r_cnt;
            r_out_bits  <= n_bits;
            r_out_last  <= last_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_index = r_out_index;
    assign o_row_bits  = r_out_bits;
    assign o_last_row  = r_out_last;

endmodule

/* design/dot_matrix_frame_buffer_top.sv */
// Top level of the 10-row by 7-column dot-matrix frame buffer.
// Depends on dmfb_pkg, dmfb_ctrl, dmfb_datapath and the assertion macro header.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command kind,
//   tdata carries the pixel row and column for set and blink.
//   Each recognized command streams all 10 frame rows on m_axis, row 0
//   first; tdata carries row index and row bits, tlast marks row 9.
//   Kind 7 is accepted and produces nothing.
//   After a request is latched, the apply state runs; then the first row
//   enters the output register, and streaming sends one row per cycle
//   unless m_axis_tready stalls; no new request is taken meanwhile.
//   s_axis_tready is high only while no command is in progress; it rises
//   again as the last row enters the output register.
//   Reset (synchronous, active low) clears the frame to zeros, the blink
//   phase to zero and drops any pending output.
//   A stall on m_axis_tready holds the current row and pauses streaming.
`include "dot_matrix_frame_buffer_top_defines.svh"
module dot_matrix_frame_buffer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] row_sel, [6:4] col_sel, [7] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] row_index, [10:4] row_bits, [15:11] zero
    output logic        m_axis_tlast    // last_row
);
    import dmfb_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_kind    req_kind;
    t_row_idx out_index;
    t_row     out_bits;

    assign req_kind = t_kind'(s_axis_tuser);

    dmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_kind  (req_kind),
        .o_req_ready (s_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    dmfb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_kind      (req_kind),
        .i_row_sel   (s_axis_tdata[3:0]),
        .i_col_sel   (s_axis_tdata[6:4]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_row_index (out_index),
        .o_row_bits  (out_bits),
        .o_last_row  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_bits, out_index};

    `DMFB_ASSERT(a_emit_free, dp_cmd.emit |-> dp_stat.out_free)
    `DMFB_ASSERT_NEXT(a_latch_apply, dp_cmd.latch, dp_cmd.apply)
    `DMFB_ASSERT_NEXT(a_apply_busy, dp_cmd.apply, !s_axis_tready)
    `DMFB_ASSERT(a_last_index, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'd9)

endmodule
